// ===== sv/sbce_pkg.sv =====
// Shared types and constants of the SCSI block command engine.
package sbce_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 512;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_BLOCKS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BYTES  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_READY        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WRITABLE     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INQ_EXTRA    = 3'd4;

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_DIN  = 2'd1;
  localparam logic [1:0] PH_DOUT = 2'd2;
  localparam logic [1:0] PH_STAT = 2'd3;

  localparam logic [7:0] OP_TUR       = 8'h00;
  localparam logic [7:0] OP_SENSE     = 8'h03;
  localparam logic [7:0] OP_INQUIRY   = 8'h12;
  localparam logic [7:0] OP_MODE6     = 8'h1A;
  localparam logic [7:0] OP_STARTSTOP = 8'h1B;
  localparam logic [7:0] OP_REMOVAL   = 8'h1E;
  localparam logic [7:0] OP_FMTCAP    = 8'h23;
  localparam logic [7:0] OP_CAP10     = 8'h25;
  localparam logic [7:0] OP_READ10    = 8'h28;
  localparam logic [7:0] OP_WRITE10   = 8'h2A;
  localparam logic [7:0] OP_VERIFY10  = 8'h2F;
  localparam logic [7:0] OP_MODE10    = 8'h5A;

  localparam logic [3:0] SK_ILLEGAL   = 4'd5;
  localparam logic [3:0] SK_NOT_READY = 4'd2;
  localparam logic [3:0] SK_MEDIUM    = 4'd4;
  localparam logic [7:0] ASC_INV_OP   = 8'h20;
  localparam logic [7:0] ASC_INV_FLD  = 8'h24;
  localparam logic [7:0] ASC_RANGE    = 8'h21;
  localparam logic [7:0] ASC_NO_MED   = 8'h3A;
  localparam logic [7:0] ASC_WPROT    = 8'h27;
  localparam logic [7:0] ASC_RD_ERR   = 8'h11;
  localparam logic [7:0] ASC_WR_FLT   = 8'h03;

  localparam logic [2:0] RK_NONE    = 3'd0;
  localparam logic [2:0] RK_INQUIRY = 3'd1;
  localparam logic [2:0] RK_VPD     = 3'd2;
  localparam logic [2:0] RK_CAP     = 3'd3;
  localparam logic [2:0] RK_FMTCAP  = 3'd4;
  localparam logic [2:0] RK_MODE    = 3'd5;
  localparam logic [2:0] RK_SENSE   = 3'd6;

  localparam logic [15:0] LEN_VPD    = 16'd5;
  localparam logic [15:0] LEN_FMTCAP = 16'd12;
  localparam logic [15:0] LEN_SENSE  = 16'd18;
  localparam logic [15:0] LEN_MODE   = 16'd8;
  localparam logic [15:0] LEN_CAP    = 16'd8;
  localparam logic [15:0] INQ_HDR    = 16'd4;

  typedef struct packed {
    logic latch;
    logic eval;
    logic div_start;
    logic div_sel_b;
    logic div_step;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

// ===== sv/sbce_dp.sv =====
// Datapath: configuration, command state, products, serial divider, output register.
module sbce_dp #(
  parameter int unsigned BUFFER_BYTES = sbce_pkg::BUFFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbce_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sbce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [sbce_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  sbce_pkg::ctl_t                    ctl,
  output sbce_pkg::sts_t                    sts,
  output logic [sbce_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [2:0]                        out_tuser
);

  localparam int unsigned CHUNK_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [31:0] BUF32 = 32'(BUFFER_BYTES);

  logic [31:0] total_blocks_r;
  logic [12:0] block_bytes_r;
  logic        ready_r, writable_r;
  logic [7:0]  inq_extra_r;

  logic        func_r, dir_r, vpd_r, bchk_r, ok_r;
  logic [7:0]  op_r;
  logic [31:0] host_r, lba_r;
  logic [15:0] nblk_r, alloc_r;

  logic [31:0] addr_prod_r;
  logic [31:0] len_prod_r;
  logic        range_bad_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] ba_r, ba_nxt, br_r, br_nxt, res_r, res_nxt;
  logic        failed_r, failed_nxt;
  logic [3:0]  key_r, key_nxt;
  logic [7:0]  code_r, code_nxt;

  logic [9:0]  xfer_r, xfer_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        mwrite_r, mwrite_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [CHUNK_W-1:0] dlen_r, dlen_nxt;
  logic [31:0] mblock_r;
  logic [9:0]  mblocks_r;
  logic        media;

  logic [13:0] rem_r;
  logic [31:0] q_r;
  logic [4:0]  cnt_r;
  logic [13:0] trial;
  logic        ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= 32'd1;
      block_bytes_r  <= 13'd512;
      ready_r        <= 1'b0;
      writable_r     <= 1'b0;
      inq_extra_r    <= 8'd31;
    end else if (cfg_we) begin
      case (cfg_addr)
        sbce_pkg::REG_TOTAL_BLOCKS: total_blocks_r <= cfg_wdata;
        sbce_pkg::REG_BLOCK_BYTES:  block_bytes_r  <= cfg_wdata[12:0];
        sbce_pkg::REG_READY:        ready_r        <= cfg_wdata[0];
        sbce_pkg::REG_WRITABLE:     writable_r     <= cfg_wdata[0];
        sbce_pkg::REG_INQ_EXTRA:    inq_extra_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      func_r  <= in_tuser;
      op_r    <= in_tdata[7:0];
      dir_r   <= in_tdata[8];
      host_r  <= in_tdata[40:9];
      lba_r   <= in_tdata[72:41];
      nblk_r  <= in_tdata[88:73];
      alloc_r <= in_tdata[104:89];
      vpd_r   <= in_tdata[105];
      bchk_r  <= in_tdata[106];
      ok_r    <= in_tdata[107];
    end
    addr_prod_r <= lba_r * {19'd0, block_bytes_r};
    len_prod_r  <= {16'd0, nblk_r} * {19'd0, block_bytes_r};
    range_bad_r <= ({1'b0, lba_r} + {17'd0, nblk_r}) > {1'b0, total_blocks_r};
  end

  always_comb begin
    logic [31:0] len;
    logic [15:0] resp;
    logic [2:0]  kind;
    logic        wr;
    phase_nxt  = phase_r;
    ba_nxt     = ba_r;
    br_nxt     = br_r;
    res_nxt    = res_r;
    failed_nxt = failed_r;
    key_nxt    = key_r;
    code_nxt   = code_r;
    xfer_nxt   = 10'd0;
    kind_nxt   = sbce_pkg::RK_NONE;
    mwrite_nxt = 1'b0;
    daddr_nxt  = ba_r;
    dlen_nxt   = '0;
    media      = 1'b0;
    len        = 32'd0;
    resp       = 16'd0;
    kind       = sbce_pkg::RK_NONE;
    wr         = (op_r == sbce_pkg::OP_WRITE10);
    if (!func_r) begin
      failed_nxt = 1'b0;
      res_nxt    = host_r;
      phase_nxt  = sbce_pkg::PH_CMD;
      case (op_r)
        sbce_pkg::OP_READ10, sbce_pkg::OP_WRITE10: begin
          if (dir_r == wr) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_INV_OP;
          end else if (!ready_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_NOT_READY;
            code_nxt = sbce_pkg::ASC_NO_MED;
          end else if (wr && !writable_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_NOT_READY;
            code_nxt = sbce_pkg::ASC_WPROT;
          end else if (range_bad_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_RANGE;
          end else begin
            ba_nxt = addr_prod_r;
            br_nxt = len_prod_r;
            len    = (len_prod_r < BUF32) ? len_prod_r : BUF32;
            if (host_r != len_prod_r) begin
              failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL;
              code_nxt = sbce_pkg::ASC_INV_OP;
            end else if (wr) begin
              phase_nxt = sbce_pkg::PH_DOUT;
              xfer_nxt  = len[9:0];
            end else begin
              phase_nxt = sbce_pkg::PH_DIN;
              media     = 1'b1;
              daddr_nxt = addr_prod_r;
              dlen_nxt  = len[CHUNK_W-1:0];
              if (!ok_r) begin
                failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_MEDIUM;
                code_nxt = sbce_pkg::ASC_RD_ERR; phase_nxt = sbce_pkg::PH_STAT;
              end else begin
                xfer_nxt = len[9:0];
                ba_nxt   = addr_prod_r + len;
                br_nxt   = len_prod_r - len;
                res_nxt  = host_r - len;
                if (len_prod_r == len) phase_nxt = sbce_pkg::PH_STAT;
              end
            end
          end
        end
        sbce_pkg::OP_VERIFY10: begin
          if (bchk_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_INV_FLD;
          end else if (range_bad_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_RANGE;
          end
        end
        sbce_pkg::OP_INQUIRY: begin
          resp = vpd_r ? sbce_pkg::LEN_VPD : ({8'd0, inq_extra_r} + sbce_pkg::INQ_HDR);
          kind = vpd_r ? sbce_pkg::RK_VPD : sbce_pkg::RK_INQUIRY;
        end
        sbce_pkg::OP_FMTCAP: begin
          resp = sbce_pkg::LEN_FMTCAP; kind = sbce_pkg::RK_FMTCAP;
        end
        sbce_pkg::OP_TUR: begin
          if (host_r != 32'd0) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_INV_OP;
          end else if (!ready_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_NOT_READY;
            code_nxt = sbce_pkg::ASC_NO_MED;
          end
        end
        sbce_pkg::OP_SENSE: begin
          resp = sbce_pkg::LEN_SENSE; kind = sbce_pkg::RK_SENSE;
        end
        sbce_pkg::OP_STARTSTOP, sbce_pkg::OP_REMOVAL: ;
        sbce_pkg::OP_MODE6, sbce_pkg::OP_MODE10: begin
          resp = sbce_pkg::LEN_MODE; kind = sbce_pkg::RK_MODE;
        end
        sbce_pkg::OP_CAP10: begin
          if (!ready_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_NOT_READY;
            code_nxt = sbce_pkg::ASC_NO_MED;
          end else begin
            resp = sbce_pkg::LEN_CAP; kind = sbce_pkg::RK_CAP;
          end
        end
        default: begin
          failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_ILLEGAL; code_nxt = sbce_pkg::ASC_INV_OP;
        end
      endcase
      if (op_r != sbce_pkg::OP_CAP10 && resp > alloc_r) resp = alloc_r;
      if ({16'd0, resp} > host_r) resp = host_r[15:0];
      if (phase_nxt == sbce_pkg::PH_CMD) begin
        if (!failed_nxt && resp != 16'd0) begin
          xfer_nxt = resp[9:0];
          kind_nxt = kind;
          res_nxt  = host_r - {16'd0, resp};
        end
        phase_nxt = sbce_pkg::PH_STAT;
      end
    end else begin
      len = (br_r < BUF32) ? br_r : BUF32;
      case (phase_r)
        sbce_pkg::PH_DIN, sbce_pkg::PH_DOUT: begin
          media      = 1'b1;
          mwrite_nxt = (phase_r == sbce_pkg::PH_DOUT);
          daddr_nxt  = ba_r;
          dlen_nxt   = len[CHUNK_W-1:0];
          if (!ok_r) begin
            failed_nxt = 1'b1; key_nxt = sbce_pkg::SK_MEDIUM;
            code_nxt  = mwrite_nxt ? sbce_pkg::ASC_WR_FLT : sbce_pkg::ASC_RD_ERR;
            phase_nxt = sbce_pkg::PH_STAT;
          end else begin
            ba_nxt  = ba_r + len;
            br_nxt  = br_r - len;
            res_nxt = res_r - len;
            if (!mwrite_nxt) begin
              xfer_nxt = len[9:0];
              if (br_nxt == 32'd0) phase_nxt = sbce_pkg::PH_STAT;
            end else if (br_nxt != 32'd0) begin
              xfer_nxt = (br_nxt < BUF32) ? br_nxt[9:0] : BUF32[9:0];
            end else begin
              phase_nxt = sbce_pkg::PH_STAT;
            end
          end
        end
        sbce_pkg::PH_STAT: phase_nxt = sbce_pkg::PH_CMD;
        default: ;
      endcase
    end
  end

  assign sts.need_div = media && (block_bytes_r != 13'd0);
  assign sts.div_last = (cnt_r == 5'(sbce_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sbce_pkg::PH_CMD;
      ba_r     <= '0;
      br_r     <= '0;
      res_r    <= '0;
      failed_r <= 1'b0;
      key_r    <= '0;
      code_r   <= '0;
    end else if (ctl.eval) begin
      phase_r  <= phase_nxt;
      ba_r     <= ba_nxt;
      br_r     <= br_nxt;
      res_r    <= res_nxt;
      failed_r <= failed_nxt;
      key_r    <= key_nxt;
      code_r   <= code_nxt;
    end
  end

  assign trial = {rem_r[12:0], q_r[31]};
  assign ge    = trial >= {1'b0, block_bytes_r};

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      xfer_r    <= xfer_nxt;
      kind_r    <= kind_nxt;
      mwrite_r  <= mwrite_nxt;
      daddr_r   <= daddr_nxt;
      dlen_r    <= dlen_nxt;
      mblock_r  <= '0;
      mblocks_r <= '0;
    end
    if (ctl.div_start) begin
      rem_r <= '0;
      cnt_r <= '0;
      q_r   <= ctl.div_sel_b ? 32'(dlen_r) : daddr_r;
    end else if (ctl.div_step) begin
      rem_r <= ge ? (trial - {1'b0, block_bytes_r}) : trial;
      q_r   <= {q_r[30:0], ge};
      cnt_r <= cnt_r + 5'd1;
      if (sts.div_last) begin
        if (ctl.div_sel_b) mblocks_r <= q_r[8:0] << 1 | {9'd0, ge};
        else mblock_r <= {q_r[30:0], ge};
      end
    end
    if (ctl.load_out) begin
      out_tdata <= {4'd0, res_r, mwrite_r, mblocks_r, mblock_r, xfer_r, phase_r,
                    code_r, key_r, failed_r};
      out_tuser <= kind_r;
    end
  end

endmodule

// ===== sv/sbce_ctrl.sv =====
// Controller state machine: sequences item capture, evaluation, division and output.
module sbce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  sbce_pkg::sts_t sts,
  output sbce_pkg::ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_EVAL   = 8'b0000_0100,
    S_DIVALD = 8'b0000_1000,
    S_DIVA   = 8'b0001_0000,
    S_DIVBLD = 8'b0010_0000,
    S_DIVB   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.latch     = in_tready && in_tvalid;
    ctl.div_sel_b = (state_r == S_DIVBLD) || (state_r == S_DIVB);
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_EVAL;
      S_EVAL: begin
        ctl.eval  = 1'b1;
        state_nxt = sts.need_div ? S_DIVALD : S_DONE;
      end
      S_DIVALD: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_DIVA;
      end
      S_DIVA: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIVBLD;
      end
      S_DIVBLD: begin
        ctl.div_start = 1'b1;
        state_nxt     = S_DIVB;
      end
      S_DIVB: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = ctl.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL))
    else $error("accepted item did not start work");
  a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown outside completion");
  a_diva_to_b: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVA && sts.div_last) |=> (state_r == S_DIVBLD))
    else $error("second division not started");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.load_out && out_valid_r) |-> out_tready)
    else $error("pending result overwritten");
`endif

endmodule

// ===== sv/scsi_block_command_engine_top.sv =====
// Top level of the SCSI block command engine.
// One item in, one result item out. When an item causes no media access, the block
// passes it through the states MUL, EVAL and DONE, where its result is loaded into
// the output register. A media chunk with a nonzero block size also passes through
// DIVALD, DIVA, DIVBLD and DIVB: the bit-serial divider turns the byte address
// and the chunk length into block numbers, one quotient bit per cycle. One item is
// worked on at a time; the next item is taken while a result waits on the output.
module scsi_block_command_engine_top #(
  parameter int unsigned BUFFER_BYTES = sbce_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sbce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode, direction_in, host_length, lba, transfer_blocks, alloc_length,
  // vpd_flag, byte_check, media_ok, zero fill
  input  logic [sbce_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cmd_failed, sense_key, sense_code, phase, xfer_bytes, media_block,
  // media_blocks, media_write, residue, zero fill
  output logic [sbce_pkg::OUT_DATA_W-1:0]  out_tdata,
  // response_kind
  output logic [2:0]                       out_tuser
);

  sbce_pkg::ctl_t ctl;
  sbce_pkg::sts_t sts;

  sbce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  sbce_dp #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ctl       (ctl),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== dv/scsi_block_command_engine_top_tb.sv =====
// Self-checking testbench of the SCSI block command engine: streams commands and chunks, predicts results.
module scsi_block_command_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_BYTES = 512;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        func;
    logic [7:0]  opcode;
    logic        dir_in;
    logic [31:0] host_len;
    logic [31:0] lba;
    logic [15:0] nblk;
    logic [15:0] alloc;
    logic        vpd;
    logic        bytchk;
    logic        ok;
  } cmd_item_t;

  typedef struct packed {
    logic        failed;
    logic [3:0]  skey;
    logic [7:0]  scode;
    logic [1:0]  phase;
    logic [9:0]  xfer;
    logic [31:0] mblock;
    logic [9:0]  mblocks;
    logic        mwrite;
    logic [31:0] residue;
    logic [2:0]  kind;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sbce_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sbce_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sbce_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sbce_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;

  scsi_block_command_engine_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and configuration.
  logic [31:0] m_total, m_bsize, m_addr, m_remain, m_resid;
  logic        m_ready, m_wr_en, m_failed;
  logic [7:0]  m_inq_extra, m_scode;
  logic [3:0]  m_skey;
  logic [1:0]  m_phase;
  status_t     m_res;

  cmd_item_t  pending_items[$];
  status_t    expected_status[$];
  int         errors = 0;
  int         accepted = 0;
  int         results_seen = 0;
  int         chunk_results = 0;
  longint     cycles = 0;
  bit         free_run = 1'b0;
  int         hold_off = 0;
  int         cur_phase = -1;
  bit         stall_done = 1'b0;

  function automatic logic [31:0] blocks_of(logic [31:0] v);
    return (m_bsize == 0) ? 32'd0 : v / m_bsize;
  endfunction

  function automatic logic [31:0] min32(logic [31:0] a, logic [31:0] b);
    return (a > b) ? b : a;
  endfunction

  function automatic void raise_sense(logic [3:0] k, logic [7:0] c);
    m_skey = k;
    m_scode = c;
    m_failed = 1'b1;
  endfunction

  function automatic void move_chunk(logic wr, logic ok);
    logic [31:0] len;
    len = min32(m_remain, BUF_BYTES);
    m_res.mblock = blocks_of(m_addr);
    m_res.mblocks = 10'(blocks_of(len));
    m_res.mwrite = wr;
    if (!ok) begin
      raise_sense(sbce_pkg::SK_MEDIUM, wr ? sbce_pkg::ASC_WR_FLT : sbce_pkg::ASC_RD_ERR);
      m_phase = sbce_pkg::PH_STAT;
      return;
    end
    if (!wr) m_res.xfer = len[9:0];
    m_addr += len;
    m_remain -= len;
    m_resid -= len;
    if (m_remain == 0) m_phase = sbce_pkg::PH_STAT;
    else if (wr) m_res.xfer = 10'(min32(m_remain, BUF_BYTES));
  endfunction

  function automatic void new_command(cmd_item_t it);
    logic [31:0] resp;
    logic [2:0] kind;
    logic wr;
    resp = 0;
    kind = sbce_pkg::RK_NONE;
    m_failed = 1'b0;
    m_resid = it.host_len;
    m_phase = sbce_pkg::PH_CMD;
    case (it.opcode)
      sbce_pkg::OP_READ10, sbce_pkg::OP_WRITE10: begin
        wr = (it.opcode == sbce_pkg::OP_WRITE10);
        if (it.dir_in == wr) raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_INV_OP);
        else if (!m_ready) raise_sense(sbce_pkg::SK_NOT_READY, sbce_pkg::ASC_NO_MED);
        else if (wr && !m_wr_en) raise_sense(sbce_pkg::SK_NOT_READY, sbce_pkg::ASC_WPROT);
        else if ({1'b0, it.lba} + {17'd0, it.nblk} > {1'b0, m_total})
          raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_RANGE);
        else begin
          m_addr = it.lba * m_bsize;
          m_remain = {16'd0, it.nblk} * m_bsize;
          if (it.host_len != m_remain) raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_INV_OP);
          else if (wr) begin
            m_phase = sbce_pkg::PH_DOUT;
            m_res.xfer = 10'(min32(m_remain, BUF_BYTES));
          end else begin
            m_phase = sbce_pkg::PH_DIN;
            move_chunk(1'b0, it.ok);
          end
        end
      end
      sbce_pkg::OP_VERIFY10: begin
        if (it.bytchk) raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_INV_FLD);
        else if ({1'b0, it.lba} + {17'd0, it.nblk} > {1'b0, m_total})
          raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_RANGE);
      end
      sbce_pkg::OP_INQUIRY: begin
        resp = min32(it.vpd ? 32'(sbce_pkg::LEN_VPD)
                            : 32'(m_inq_extra) + 32'(sbce_pkg::INQ_HDR), 32'(it.alloc));
        kind = it.vpd ? sbce_pkg::RK_VPD : sbce_pkg::RK_INQUIRY;
      end
      sbce_pkg::OP_FMTCAP: begin
        resp = min32(32'(sbce_pkg::LEN_FMTCAP), 32'(it.alloc));
        kind = sbce_pkg::RK_FMTCAP;
      end
      sbce_pkg::OP_TUR: begin
        if (it.host_len != 0) raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_INV_OP);
        else if (!m_ready) raise_sense(sbce_pkg::SK_NOT_READY, sbce_pkg::ASC_NO_MED);
      end
      sbce_pkg::OP_SENSE: begin
        resp = min32(32'(sbce_pkg::LEN_SENSE), 32'(it.alloc));
        kind = sbce_pkg::RK_SENSE;
      end
      sbce_pkg::OP_STARTSTOP, sbce_pkg::OP_REMOVAL: ;
      sbce_pkg::OP_MODE6, sbce_pkg::OP_MODE10: begin
        resp = min32(32'(sbce_pkg::LEN_MODE), 32'(it.alloc));
        kind = sbce_pkg::RK_MODE;
      end
      sbce_pkg::OP_CAP10: begin
        if (!m_ready) raise_sense(sbce_pkg::SK_NOT_READY, sbce_pkg::ASC_NO_MED);
        else begin
          resp = 32'(sbce_pkg::LEN_CAP);
          kind = sbce_pkg::RK_CAP;
        end
      end
      default: raise_sense(sbce_pkg::SK_ILLEGAL, sbce_pkg::ASC_INV_OP);
    endcase
    resp = min32(resp, it.host_len);
    if (m_phase == sbce_pkg::PH_CMD) begin
      if (!m_failed && resp > 0) begin
        m_res.xfer = resp[9:0];
        m_res.kind = kind;
        m_resid -= resp;
      end
      m_phase = sbce_pkg::PH_STAT;
    end
  endfunction

  function automatic status_t predict_status(cmd_item_t it);
    m_res = '0;
    if (!it.func) new_command(it);
    else if (m_phase == sbce_pkg::PH_DIN) move_chunk(1'b0, it.ok);
    else if (m_phase == sbce_pkg::PH_DOUT) move_chunk(1'b1, it.ok);
    else if (m_phase == sbce_pkg::PH_STAT) m_phase = sbce_pkg::PH_CMD;
    m_res.failed = m_failed;
    m_res.skey = m_skey;
    m_res.scode = m_scode;
    m_res.phase = m_phase;
    m_res.residue = m_resid;
    return m_res;
  endfunction

  // Driver.
  always @(negedge clk) begin
    cmd_item_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_items.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_items.size() > 0 && (free_run || $urandom_range(99) >= 31)) begin
          it = pending_items[0];
          in_tvalid <= 1'b1;
          in_tuser <= it.func;
          in_tdata <= sbce_pkg::IN_DATA_W'({it.ok, it.bytchk, it.vpd, it.alloc, it.nblk,
                                            it.lba, it.host_len, it.dir_in, it.opcode});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver, with one long hold-off that is counted here.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!stall_done && cur_phase == 1) begin
        stall_done <= 1'b1;
        hold_off <= 400;
        out_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= free_run || $urandom_range(99) >= 31;
      end
    end
  end

  // Input monitor runs the predictor on each accepted item.
  always @(posedge clk) begin
    cmd_item_t it;
    cycles++;
    if (rst_n && in_tvalid && in_tready) begin
      it = pending_items[0];
      expected_status.push_back(predict_status(it));
      accepted++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $realtime);
      $display("scsi_block_command_engine_top_tb: FAIL");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    status_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.failed = out_tdata[0];
      got.skey = out_tdata[4:1];
      got.scode = out_tdata[12:5];
      got.phase = out_tdata[14:13];
      got.xfer = out_tdata[24:15];
      got.mblock = out_tdata[56:25];
      got.mblocks = out_tdata[66:57];
      got.mwrite = out_tdata[67];
      got.residue = out_tdata[99:68];
      results_seen++;
      if (got.mblocks != 0 || got.mwrite) chunk_results++;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        if (got !== exp_s) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_s, got);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [sbce_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sbce_pkg::REG_TOTAL_BLOCKS: m_total = val;
      sbce_pkg::REG_BLOCK_BYTES: m_bsize = val & 32'h1FFF;
      sbce_pkg::REG_READY: m_ready = val[0];
      sbce_pkg::REG_WRITABLE: m_wr_en = val[0];
      default: m_inq_extra = val[7:0];
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_items.size() != 0 || expected_status.size() != 0) && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  function automatic cmd_item_t make_cmd(logic [7:0] op, logic dir, logic [31:0] host,
                                         logic [31:0] lba, logic [15:0] nblk,
                                         logic [15:0] alloc);
    cmd_item_t it;
    it = '0;
    it.opcode = op;
    it.dir_in = dir;
    it.host_len = host;
    it.lba = lba;
    it.nblk = nblk;
    it.alloc = alloc;
    it.ok = 1'b1;
    return it;
  endfunction

  function automatic cmd_item_t chunk_done(logic ok);
    cmd_item_t it;
    it = '0;
    it.func = 1'b1;
    it.ok = ok;
    it.opcode = 8'($urandom);
    return it;
  endfunction

  // A transfer command followed by enough chunk completions to finish it.
  task automatic queue_transfer(bit wr);
    cmd_item_t it;
    int n, chunks;
    logic [31:0] bytes;
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
    it = make_cmd(wr ? sbce_pkg::OP_WRITE10 : sbce_pkg::OP_READ10, !wr, 0,
                  $urandom_range(0, (m_total > n) ? (m_total - n) % 1000 : 0), 16'(n), 0);
    bytes = n * m_bsize;
    it.host_len = ($urandom_range(15) == 0) ? bytes + 1 : bytes;
    it.ok = $urandom_range(19) != 0;
    if ($urandom_range(19) == 0) it.lba = $urandom;
    if ($urandom_range(29) == 0) it.dir_in = wr;
    pending_items.push_back(it);
    chunks = (bytes + BUF_BYTES - 1) / BUF_BYTES + 1;
    for (int i = 0; i < chunks; i++) pending_items.push_back(chunk_done($urandom_range(24) != 0));
  endtask

  function automatic cmd_item_t random_cmd();
    logic [7:0] ops[12];
    cmd_item_t it;
    ops = '{sbce_pkg::OP_TUR, sbce_pkg::OP_SENSE, sbce_pkg::OP_INQUIRY, sbce_pkg::OP_MODE6,
            sbce_pkg::OP_STARTSTOP, sbce_pkg::OP_REMOVAL, sbce_pkg::OP_FMTCAP,
            sbce_pkg::OP_CAP10, sbce_pkg::OP_READ10, sbce_pkg::OP_WRITE10,
            sbce_pkg::OP_VERIFY10, sbce_pkg::OP_MODE10};
    it = '0;
    it.func = $urandom_range(4) == 0;
    it.opcode = ($urandom_range(9) == 0) ? 8'($urandom) : ops[$urandom_range(11)];
    it.dir_in = $urandom;
    it.host_len = ($urandom_range(2) == 0) ? $urandom : $urandom_range(40);
    it.lba = ($urandom_range(1) == 0) ? $urandom : $urandom_range(20);
    it.nblk = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    it.alloc = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(30));
    it.vpd = $urandom;
    it.bytchk = $urandom;
    it.ok = $urandom;
    if (it.opcode == sbce_pkg::OP_TUR && $urandom_range(1) == 0) it.host_len = 0;
    return it;
  endfunction

  initial begin
    logic [31:0] sizes[6];
    sizes = '{512, 1, 4096, 0, 100, 2048};
    m_total = 1; m_bsize = 512; m_ready = 0; m_wr_en = 0; m_inq_extra = 31;
    m_phase = sbce_pkg::PH_CMD; m_addr = 0; m_remain = 0; m_resid = 0;
    m_failed = 0; m_skey = 0; m_scode = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: not ready, so most commands fail.
    pending_items.push_back(make_cmd(sbce_pkg::OP_TUR, 0, 0, 0, 0, 0));
    pending_items.push_back(make_cmd(sbce_pkg::OP_READ10, 1, 512, 0, 1, 0));
    pending_items.push_back(make_cmd(sbce_pkg::OP_SENSE, 1, 32'hFFFF_FFFF, 0, 0, 16'hFFFF));
    pending_items.push_back(chunk_done(1));
    pending_items.push_back(chunk_done(1));
    pending_items.push_back(make_cmd(sbce_pkg::OP_CAP10, 1, 8, 0, 0, 0));
    drain();

    write_reg(sbce_pkg::REG_TOTAL_BLOCKS, 32'hFFFF_FFFF);
    write_reg(sbce_pkg::REG_BLOCK_BYTES, 4096);
    write_reg(sbce_pkg::REG_READY, 1);
    write_reg(sbce_pkg::REG_WRITABLE, 1);
    write_reg(sbce_pkg::REG_INQ_EXTRA, 255);
    pending_items.push_back(make_cmd(sbce_pkg::OP_INQUIRY, 1, 300, 0, 0, 16'hFFFF));
    pending_items.push_back(make_cmd(sbce_pkg::OP_INQUIRY, 1, 300, 0, 0, 0));
    begin
      cmd_item_t v;
      v = make_cmd(sbce_pkg::OP_INQUIRY, 1, 3, 0, 0, 100); v.vpd = 1;
      pending_items.push_back(v);
      v = make_cmd(sbce_pkg::OP_VERIFY10, 0, 0, 32'hFFFF_FFF0, 16'hFFFF, 0); v.bytchk = 1;
      pending_items.push_back(v);
    end
    pending_items.push_back(make_cmd(sbce_pkg::OP_VERIFY10, 0, 0, 32'hFFFF_FFF0, 16'hFFFF, 0));
    pending_items.push_back(make_cmd(sbce_pkg::OP_VERIFY10, 0, 0, 32'hFFFF_FFF0, 15, 0));
    pending_items.push_back(make_cmd(sbce_pkg::OP_FMTCAP, 1, 64, 0, 0, 100));
    pending_items.push_back(make_cmd(sbce_pkg::OP_MODE6, 1, 64, 0, 0, 4));
    pending_items.push_back(make_cmd(sbce_pkg::OP_MODE10, 1, 64, 0, 0, 100));
    pending_items.push_back(make_cmd(sbce_pkg::OP_STARTSTOP, 0, 0, 0, 0, 0));
    pending_items.push_back(make_cmd(sbce_pkg::OP_REMOVAL, 0, 0, 0, 0, 0));
    pending_items.push_back(make_cmd(8'hFF, 1, 0, 0, 0, 0));
    // Wide address wraps, and a large block yields zero block counts.
    pending_items.push_back(make_cmd(sbce_pkg::OP_READ10, 1, 4096, 32'h0010_0001, 1, 0));
    for (int i = 0; i < 9; i++) pending_items.push_back(chunk_done(1));
    pending_items.push_back(make_cmd(sbce_pkg::OP_WRITE10, 0, 0, 5, 0, 0));
    pending_items.push_back(chunk_done(0));
    drain();

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      write_reg(sbce_pkg::REG_BLOCK_BYTES, sizes[phase_no]);
      write_reg(sbce_pkg::REG_TOTAL_BLOCKS, (phase_no == 3) ? 32'd1 : $urandom_range(1, 2000));
      write_reg(sbce_pkg::REG_READY, 32'(phase_no != 4));
      write_reg(sbce_pkg::REG_WRITABLE, 32'(phase_no % 2));
      write_reg(sbce_pkg::REG_INQ_EXTRA, $urandom_range(255));
      free_run = (phase_no == 2);
      cur_phase = phase_no;
      for (int k = 0; k < 22; k++) begin
        if ($urandom_range(2) != 0) queue_transfer($urandom_range(1));
        else pending_items.push_back(random_cmd());
      end
      drain();
    end
    free_run = 1'b0;

    $display("Run covered %0d items, %0d results, %0d of them media chunks.",
             accepted, results_seen, chunk_results);
    $display("Commands, chunk completions, sense failures and several block sizes were checked.");
    if (errors == 0 && expected_status.size() == 0)
      $display("scsi_block_command_engine_top_tb: PASS");
    else
      $display("scsi_block_command_engine_top_tb: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/sbce_pkg.sv
sv/sbce_dp.sv
sv/sbce_ctrl.sv
sv/scsi_block_command_engine_top.sv
dv/scsi_block_command_engine_top_tb.sv
